// ----- hdl/mf3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and small sorting helpers for the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int LS_AW       = $clog2(MAX_WIDTH);
  localparam int COL_W       = 11;
  localparam int ROW_W       = 12;
  localparam int CFG_W       = 12;
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [CFG_W-1:0] DIM_MIN      = 12'd3;
  localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    logic [COL_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    chan_t            alpha;
    logic             last;
    logic             frame_done;
  } res_t;

  // {hi, mid, lo}
  function automatic logic [23:0] sort3(input chan_t a, input chan_t b, input chan_t c);
    chan_t lo1, hi1, lo, mid, hi;
    lo1 = (a < b) ? a : b;
    hi1 = (a < b) ? b : a;
    hi  = (hi1 < c) ? c : hi1;
    mid = (hi1 < c) ? hi1 : c;
    lo  = (lo1 < mid) ? lo1 : mid;
    mid = (lo1 < mid) ? mid : lo1;
    return {hi, mid, lo};
  endfunction

  function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
    chan_t m;
    m = (a < b) ? b : a;
    return (m < c) ? c : m;
  endfunction

  function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
    chan_t m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
    logic [23:0] s;
    s = sort3(a, b, c);
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mf3_line_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_line_store
// Two row memories (row above, two rows above), registered read.
// ----------------------------------------------------------------------------
module mf3_line_store (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [mf3_pkg::LS_AW-1:0] rd_addr,
  output logic [31:0]                    rd_above,
  output logic [31:0]                    rd_two_above,
  input  wire logic                      wr_en,
  input  wire logic [mf3_pkg::LS_AW-1:0] wr_addr,
  input  wire logic [31:0]               wr_above,
  input  wire logic [31:0]               wr_two_above
);
  import mf3_pkg::*;

  logic [31:0] mem_above [MAX_WIDTH];
  logic [31:0] mem_two   [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_above[wr_addr] <= wr_above;
      mem_two[wr_addr]   <= wr_two_above;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_above     <= mem_above[rd_addr];
      rd_two_above <= mem_two[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mf3_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_out_queue
// Small result queue; takes up to two words per cycle, gives one.
// ----------------------------------------------------------------------------
module mf3_out_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push0,
  input  wire logic          push1,
  input  wire mf3_pkg::res_t din0,
  input  wire mf3_pkg::res_t din1,
  output logic               room2,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mf3_pkg::res_t      dout
);
  import mf3_pkg::*;

  res_t             q_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, rp_r;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic             pop;
  logic [1:0]       npush;

  assign out_valid = (cnt_r != '0);
  assign dout      = q_mem[rp_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (cnt_r <= (OQ_AW+1)'(OQ_DEPTH - 2));
  assign npush     = {1'b0, push0} + {1'b0, push1};
  assign cnt_nxt   = cnt_r + (OQ_AW+1)'(npush) - (OQ_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push0) q_mem[wp_r] <= din0;
    if (push1) q_mem[wp_r + OQ_AW'(push0)] <= din1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + OQ_AW'(npush);
      rp_r  <= rp_r + OQ_AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/median_filter_3x3_rgba.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_rgba
// Streaming 3x3 median filter on RGBA raster pixels with coordinate tags (RGB only; alpha from centre).
// ----------------------------------------------------------------------------
// A result passes stage 1, stage 2 and the result queue before it shows on out_valid.
// Throughput: one pixel per cycle while out_ready stays high; on the bottom row each
// word from column 2 on gives two results and the output port, one result a cycle,
// halves the rate there. Row ends are absorbed by the result queue.
// Line store reads are registered (read at accept, write back the next stage).
// Reset: counters, window, pipeline and queue clear; line stores are not cleared.
module median_filter_3x3_rgba (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      out_pos_x,
  output logic [11:0]      out_pos_y,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic             out_last,
  output logic             out_frame_done,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import mf3_pkg::*;

  // configuration
  logic [CFG_W-1:0] width_r, height_r, w_eff, h_eff;
  logic             cfg_wr;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {20'd0, (cfg_paddr[2] == REG_HEIGHT) ? height_r : width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WIDTH) width_r  <= cfg_pwdata[CFG_W-1:0];
      else                           height_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    w_eff = width_r;
    if (width_r < DIM_MIN)   w_eff = DIM_MIN;
    if (width_r > WIDTH_MAX) w_eff = WIDTH_MAX;
    h_eff = (height_r < DIM_MIN) ? DIM_MIN : height_r;
  end
  assign w_m1 = COL_W'(w_eff - 12'd1);
  assign h_m1 = h_eff - 12'd1;

  // pipeline control
  logic en, accept, room2;
  assign en       = room2;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  // position counters
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             row_end0, col_end0;
  assign row_end0 = (col_r >= w_m1);
  assign col_end0 = (row_r >= h_m1);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (row_end0) begin
        col_r <= '0;
        row_r <= col_end0 ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // stage 1: line store data arrives
  logic             v1_r;
  logic [31:0]      px1_r;
  logic [COL_W-1:0] c1_r;
  logic [ROW_W-1:0] r1_r;
  logic             re1_r, ce1_r;
  logic [31:0]      rd_mid, rd_top;
  logic [31:0]      win_r [6];
  logic             adv1;

  assign adv1 = en && v1_r;

  mf3_line_store u_ls (
    .clk          (clk),
    .rd_en        (accept),
    .rd_addr      (col_r),
    .rd_above     (rd_mid),
    .rd_two_above (rd_top),
    .wr_en        (adv1),
    .wr_addr      (c1_r),
    .wr_above     (px1_r),
    .wr_two_above (rd_mid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1_r <= {in_alpha, in_blue, in_green, in_red};
      c1_r  <= col_r;
      r1_r  <= row_r;
      re1_r <= row_end0;
      ce1_r <= col_end0;
    end
  end

  // window: shift in the new column
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (adv1) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= rd_top;
      win_r[4] <= rd_mid;
      win_r[5] <= px1_r;
    end
  end

  // stage 2: columns sorted, finish medians
  logic                   v2_r, int2_r, bord2_r, fd2_r;
  logic [2:0][2:0][23:0]  srt2_r;
  logic [31:0]            px2_r;
  chan_t                  ac2_r;
  logic [COL_W-1:0]       c2_r;
  logic [ROW_W-1:0]       r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int k = 0; k < 3; k++) begin
        srt2_r[k][0] <= sort3(win_r[0][8*k +: 8], win_r[1][8*k +: 8], win_r[2][8*k +: 8]);
        srt2_r[k][1] <= sort3(win_r[3][8*k +: 8], win_r[4][8*k +: 8], win_r[5][8*k +: 8]);
        srt2_r[k][2] <= sort3(rd_top[8*k +: 8], rd_mid[8*k +: 8], px1_r[8*k +: 8]);
      end
      px2_r   <= px1_r;
      ac2_r   <= win_r[4][31:24];
      c2_r    <= c1_r;
      r2_r    <= r1_r;
      int2_r  <= (c1_r >= COL_W'(2)) && (r1_r >= ROW_W'(2));
      bord2_r <= (r1_r == '0) || ce1_r || (c1_r == '0) || re1_r;
      fd2_r   <= re1_r && ce1_r;
    end
  end

  chan_t [2:0] med;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      med[k] = med3(max3(srt2_r[k][0][7:0],   srt2_r[k][1][7:0],   srt2_r[k][2][7:0]),
                    med3(srt2_r[k][0][15:8],  srt2_r[k][1][15:8],  srt2_r[k][2][15:8]),
                    min3(srt2_r[k][0][23:16], srt2_r[k][1][23:16], srt2_r[k][2][23:16]));
    end
  end

  res_t res_int, res_bord, din0, din1, qout;
  logic push_int, push_bord, push0, push1;

  always_comb begin
    res_int.pos_x      = c2_r - 1'b1;
    res_int.pos_y      = r2_r - 1'b1;
    res_int.red        = med[0];
    res_int.green      = med[1];
    res_int.blue       = med[2];
    res_int.alpha      = ac2_r;
    res_int.last       = !bord2_r;
    res_int.frame_done = 1'b0;
    res_bord.pos_x      = c2_r;
    res_bord.pos_y      = r2_r;
    res_bord.red        = px2_r[7:0];
    res_bord.green      = px2_r[15:8];
    res_bord.blue       = px2_r[23:16];
    res_bord.alpha      = px2_r[31:24];
    res_bord.last       = 1'b1;
    res_bord.frame_done = fd2_r;
  end

  assign push_int  = en && v2_r && int2_r;
  assign push_bord = en && v2_r && bord2_r;
  // interior word goes first when both are present
  assign push0 = push_int || push_bord;
  assign push1 = push_int && push_bord;
  assign din0  = push_int ? res_int : res_bord;
  assign din1  = res_bord;

  mf3_out_queue u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .din0      (din0),
    .din1      (din1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (qout)
  );

  assign out_pos_x      = qout.pos_x;
  assign out_pos_y      = qout.pos_y;
  assign out_red        = qout.red;
  assign out_green      = qout.green;
  assign out_blue       = qout.blue;
  assign out_alpha      = qout.alpha;
  assign out_last       = qout.last;
  assign out_frame_done = qout.frame_done;

endmodule
`default_nettype wire

// ----- hdl/mf3_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks on the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf3_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_last,
  input wire logic        out_frame_done,
  input wire logic [10:0] out_pos_x,
  input wire logic        cfg_pready
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x))
    else $error("result word dropped or changed while stalled");

  // frame end result closes its run
  a_fd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last)
    else $error("frame_done without last");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind median_filter_3x3_rgba mf3_checker u_mf3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_last       (out_last),
  .out_frame_done (out_frame_done),
  .out_pos_x      (out_pos_x),
  .cfg_pready     (cfg_pready)
);
`default_nettype wire
